// File: rtl/b62_pkg.sv
// shared types, constants and the digit-to-character function of the base-62 encoder
`default_nettype none

package b62_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned RADIX      = 62;
  localparam int unsigned HALF_RADIX = RADIX / 2;
  localparam int unsigned DIGIT_W    = 6;
  localparam int unsigned MAX_DIGITS = 11;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned CNT_W      = $clog2(VALUE_W);
  localparam int unsigned LEFT_W     = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_UPPER = 7'd65;
  localparam logic [CHAR_W-1:0] ASCII_LOWER = 7'd97;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_t;

  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_RUN,
    CONV_HOLD
  } conv_state_t;

  typedef enum logic [1:0] {
    EMIT_IDLE,
    EMIT_SKIP,
    EMIT_SEND
  } emit_state_t;

  // handoff of a finished numeral from the converter to the serializer
  typedef struct packed {
    logic    valid;
    digits_t digits;
  } num_hand_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input digit_t d);
    logic [CHAR_W-1:0] d7;
    logic [CHAR_W-1:0] res;
    d7 = {1'b0, d};
    if (d inside {[0:9]}) begin
      res = d7 + ASCII_ZERO;
    end else if (d inside {[10:35]}) begin
      res = d7 - 7'd10 + ASCII_UPPER;
    end else begin
      res = d7 - 7'd36 + ASCII_LOWER;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/b62_conv.sv
// bit-serial binary to base-62 converter: one input bit per cycle into a row of digit cells
`default_nettype none

module b62_conv (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start_valid,
  output logic                              start_ready,
  input  wire logic [b62_pkg::VALUE_W-1:0]  value,
  output b62_pkg::num_hand_t                hand,
  input  wire logic                         hand_ready
);

  b62_pkg::conv_state_t state_r, state_nxt;
  logic [b62_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [b62_pkg::VALUE_W-1:0] val_r;
  b62_pkg::digits_t            dig_r, dig_dbl;
  logic                        start;
  logic                        last_bit;

  assign start    = start_valid && start_ready;
  assign last_bit = (cnt_r == b62_pkg::CNT_W'(b62_pkg::VALUE_W - 1));

  // each cell doubles its digit and adds the carry from the cell below;
  // a carry leaves a cell exactly when its digit is at least half the radix
  always_comb begin
    for (int i = 0; i < int'(b62_pkg::MAX_DIGITS); i++) begin
      logic                      cin;
      logic [b62_pkg::DIGIT_W:0] dbl;
      cin = (i == 0) ? val_r[b62_pkg::VALUE_W-1]
                     : (dig_r[(i == 0) ? 0 : i-1] >= b62_pkg::DIGIT_W'(b62_pkg::HALF_RADIX));
      dbl = {dig_r[i], cin};
      if (dig_r[i] >= b62_pkg::DIGIT_W'(b62_pkg::HALF_RADIX)) begin
        dbl = dbl - (b62_pkg::DIGIT_W+1)'(b62_pkg::RADIX);
      end
      dig_dbl[i] = dbl[b62_pkg::DIGIT_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      b62_pkg::CONV_IDLE: begin
        if (start_valid) begin
          state_nxt = b62_pkg::CONV_RUN;
          cnt_nxt   = '0;
        end
      end
      b62_pkg::CONV_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last_bit) begin
          state_nxt = b62_pkg::CONV_HOLD;
        end
      end
      b62_pkg::CONV_HOLD: begin
        if (hand_ready) begin
          state_nxt = b62_pkg::CONV_IDLE;
        end
      end
      default: begin
        state_nxt = b62_pkg::CONV_IDLE;
      end
    endcase
  end

  always_comb begin
    start_ready = (state_r == b62_pkg::CONV_IDLE);
    hand.valid  = (state_r == b62_pkg::CONV_HOLD);
    hand.digits = dig_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= b62_pkg::CONV_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r <= value;
      dig_r <= '0;
    end else if (state_r == b62_pkg::CONV_RUN) begin
      val_r <= {val_r[b62_pkg::VALUE_W-2:0], 1'b0};
      dig_r <= dig_dbl;
    end
  end

endmodule

`default_nettype wire

// File: rtl/b62_emit.sv
// digit serializer: drops leading zeros and sends one character per word, top digit first
`default_nettype none

module b62_emit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire b62_pkg::num_hand_t           hand,
  output logic                              hand_ready,
  output logic                              ch_valid,
  input  wire logic                         ch_ready,
  output logic [b62_pkg::CHAR_W-1:0]        ch_code,
  output logic                              ch_last
);

  b62_pkg::emit_state_t        state_r, state_nxt;
  logic [b62_pkg::LEFT_W-1:0]  left_r, left_nxt;
  b62_pkg::digits_t            dig_r;
  b62_pkg::digit_t             top;
  logic                        load;
  logic                        shift;
  logic                        one_left;
  logic                        sent;

  assign top      = dig_r[b62_pkg::MAX_DIGITS-1];
  assign one_left = (left_r == b62_pkg::LEFT_W'(1));
  assign load     = hand.valid && hand_ready;
  assign sent     = ch_valid && ch_ready;

  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    shift     = 1'b0;
    case (state_r)
      b62_pkg::EMIT_IDLE: begin
        if (hand.valid) begin
          state_nxt = b62_pkg::EMIT_SKIP;
          left_nxt  = b62_pkg::LEFT_W'(b62_pkg::MAX_DIGITS);
        end
      end
      b62_pkg::EMIT_SKIP: begin
        // a zero value keeps its last digit
        if (top == '0 && !one_left) begin
          shift    = 1'b1;
          left_nxt = left_r - 1'b1;
        end else begin
          state_nxt = b62_pkg::EMIT_SEND;
        end
      end
      b62_pkg::EMIT_SEND: begin
        if (ch_ready) begin
          if (one_left) begin
            state_nxt = b62_pkg::EMIT_IDLE;
          end else begin
            shift    = 1'b1;
            left_nxt = left_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = b62_pkg::EMIT_IDLE;
      end
    endcase
  end

  always_comb begin
    hand_ready = (state_r == b62_pkg::EMIT_IDLE);
    ch_valid   = (state_r == b62_pkg::EMIT_SEND);
    ch_code    = b62_pkg::digit_to_ascii(top);
    ch_last    = one_left;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= b62_pkg::EMIT_IDLE;
      left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dig_r <= hand.digits;
    end else if (shift || (sent && !one_left)) begin
      dig_r <= {dig_r[b62_pkg::MAX_DIGITS-2:0], b62_pkg::DIGIT_W'(0)};
    end
  end

endmodule

`default_nettype wire

// File: rtl/base62_digit_encoder_top.sv
// top level of the base-62 encoder: 64-bit value in, ascii numeral out one character a word
`default_nettype none

// path: an accepted value gives its first character after bit-serial conversion of all 64
// bits, the handoff, one top-digit test, up to ten zero skips and one send
// throughput: the converter takes a new value once its digits are handed to the serializer;
// characters leave at up to one per cycle while out_tready is high, as the next value converts
// reset: synchronous active-low rst_n idles both stages and drops out_tvalid; no data kept

module base62_digit_encoder_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [b62_pkg::IN_DATA_W-1:0]     in_tdata,   // [63:0] value
  // result channel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [b62_pkg::OUT_DATA_W-1:0]         out_tdata,  // [6:0] char_code, [7] zero pad
  output logic                                   out_tlast   // last character of the numeral
);

  b62_pkg::num_hand_t            hand;
  logic                          hand_ready;
  logic [b62_pkg::CHAR_W-1:0]    ch_code;

  // converter: shifts the value in msb first, doubling a row of base-62 digit cells
  b62_conv u_conv (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_valid (in_tvalid),
    .start_ready (in_tready),
    .value       (in_tdata[b62_pkg::VALUE_W-1:0]),
    .hand        (hand),
    .hand_ready  (hand_ready)
  );

  // serializer: holds the finished digits so the converter is free for the next value
  b62_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .hand       (hand),
    .hand_ready (hand_ready),
    .ch_valid   (out_tvalid),
    .ch_ready   (out_tready),
    .ch_code    (ch_code),
    .ch_last    (out_tlast)
  );

  // character code in the low bits, top bit padded to a whole byte
  assign out_tdata = {{(b62_pkg::OUT_DATA_W - b62_pkg::CHAR_W){1'b0}}, ch_code};

endmodule

`default_nettype wire

// File: rtl/b62_chk.sv
// port-level checker for the base-62 encoder and its bind to the top level
`default_nettype none

module b62_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic [b62_pkg::IN_DATA_W-1:0]     in_tdata,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [b62_pkg::OUT_DATA_W-1:0]    out_tdata,
  input wire logic                              out_tlast
);

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output word changed");

  // every character is a base-62 digit
  a_out_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata >= 8'd48 && out_tdata <= 8'd57) ||
                   (out_tdata >= 8'd65 && out_tdata <= 8'd90) ||
                   (out_tdata >= 8'd97 && out_tdata <= 8'd122))
    else $error("output word is not a base-62 character");

  // converter is busy right after taking a value
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while converting");

  // no character right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // the serializer is idle in the cycle after the last character of a numeral is taken
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("output valid right after the last character");

endmodule

bind base62_digit_encoder_top b62_chk u_b62_chk (.*);

`default_nettype wire
